// ----- hw/rtl/ksd_pkg.sv -----
// Package for the two-state speed/distance Kalman filter.
// Holds shared widths, fixed-point constants, opcode codes and the operation struct.
// No dependencies.
package ksd_pkg;

    localparam int unsigned MAG_W = 63;
    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
    localparam logic signed [47:0] COV_INIT = 48'sd429497;
    localparam logic [62:0] MAG_CAP = 63'h4000_0000_0000_0000;

    // Opcodes of the shared multiply/divide unit.
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;

    typedef struct packed {
        logic               start;
        logic [1:0]         op;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [5:0]         sh;
    } alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } alu_rsp_t;

    // Saturate a 64-bit signed value to 48 bits.
    function automatic logic signed [63:0] sat48(input logic signed [63:0] x);
        logic signed [63:0] r;
        begin
            if (x > 64'(MAX48))
                r = 64'(MAX48);
            else if (x < 64'(MIN48))
                r = 64'(MIN48);
            else
                r = x;
            return r;
        end
    endfunction

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [63:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] r;
        begin
            if (x > 64'sd2147483647)
                r = 64'sd2147483647;
            else if (x < -64'sd2147483648)
                r = -64'sd2147483648;
            else
                r = x;
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/ksd_if.sv -----
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; the payload width is given by parameter W.
interface ksd_if #(
    parameter int unsigned W = 32
) (
    input logic clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ksd_alu.sv -----
// Shared arithmetic unit: rounded multiply-and-shift and gain divide.
// Uses ksd_pkg for the request and response structs.
module ksd_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  ksd_pkg::alu_req_t req,
    output ksd_pkg::alu_rsp_t rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SHF  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_QUO  = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [1:0]   step_reg, step_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         neg_reg, neg_next;
    logic [63:0]  x_reg, x_next;
    logic [63:0]  y_reg, y_next;
    logic [127:0] acc_reg, acc_next;
    logic [5:0]   sh_reg, sh_next;
    logic [63:0]  rem_reg, rem_next;
    logic [47:0]  q_reg, q_next;
    logic         over_reg, over_next;
    logic [63:0]  res_reg, res_next;
    logic         done_reg, done_next;

    logic [63:0]  pp;
    logic [31:0]  xs, ys;
    logic [127:0] rounded, shifted;
    logic [63:0]  mag;
    logic [64:0]  rtry;
    logic         nbit;

    always_comb
    begin
        // One 32x32 partial product per cycle.
        xs = step_reg[0] ? x_reg[63:32] : x_reg[31:0];
        ys = step_reg[1] ? y_reg[63:32] : y_reg[31:0];
        pp = 64'(xs) * 64'(ys);
        rounded = acc_reg + (128'd1 << (sh_reg - 6'd1));
        shifted = rounded >> sh_reg;
        mag = (shifted[127:63] != '0 || shifted[62:0] > ksd_pkg::MAG_CAP)
            ? 64'(ksd_pkg::MAG_CAP) : shifted[63:0];
        nbit = (cnt_reg >= 7'd32) ? x_reg[6'(cnt_reg - 7'd32)] : 1'b0;
        rtry = {rem_reg, nbit};
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        x_next = x_reg;
        y_next = y_reg;
        acc_next = acc_reg;
        sh_next = sh_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        over_next = over_reg;
        res_next = res_reg;
        done_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    x_next = req.a[63] ? 64'(-req.a) : req.a;
                    y_next = req.b[63] ? 64'(-req.b) : req.b;
                    sh_next = req.sh;
                    acc_next = '0;
                    step_next = '0;
                    rem_next = '0;
                    q_next = '0;
                    over_next = 1'b0;
                    cnt_next = 7'd79;
                    if (req.op == ksd_pkg::OP_DIV)
                    begin
                        neg_next = req.a[63];
                        y_next = req.b;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        neg_next = req.a[63] ^ req.b[63];
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                acc_next = acc_reg + (128'(pp) << (7'(step_reg[0]) * 7'd32
                                                  + 7'(step_reg[1]) * 7'd32));
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = S_SHF;
            end
            S_SHF:
            begin
                res_next = neg_reg ? 64'(-mag) : mag;
                state_next = S_FIN;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (rtry >= 65'(y_reg))
                begin
                    rem_next = 64'(rtry - 65'(y_reg));
                    if (cnt_reg >= 7'd47)
                        over_next = 1'b1;
                    else
                        q_next = q_reg | (48'd1 << cnt_reg[5:0]);
                end
                else
                    rem_next = rtry[63:0];
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                    state_next = S_QUO;
            end
            S_FIN:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            S_QUO:
            begin
                if (over_reg || q_reg[47])
                    res_next = neg_reg ? -64'(ksd_pkg::MAX48) : 64'(ksd_pkg::MAX48);
                else
                    res_next = neg_reg ? -64'(q_reg) : 64'(q_reg);
                state_next = S_FIN;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        x_reg <= x_next;
        y_reg <= y_next;
        acc_reg <= acc_next;
        sh_reg <= sh_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        over_reg <= over_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res = res_reg;

endmodule

// ----- hw/rtl/kalman_speed_distance_2state.sv -----
// Top level of the two-state speed/distance Kalman filter.
// Depends on ksd_pkg, ksd_if and ksd_alu.
//
// Usage: input items (dist_left, dist_right, speed_left, speed_right, fwd_accel)
// arrive on in_ch; one result (est_speed, est_distance, integ_distance) leaves
// on out_ch for each item. Registers tick_period, speed_noise_var and
// accel_noise_var are written through the APB port at byte addresses 0, 4, 8
// while the block is idle; the user must keep to this, the block does not
// enforce it. Reads return the stored value. One item runs a microprogram of
// 18 operations on the single shared multiply/divide unit: two gain divides,
// then multiplies; when the gain denominator is not positive the divides are
// skipped and 16 operations run. The block takes one item at a time and takes
// no new item before the result of the last one has been transferred.
// Reset: state returns to zero estimates, diagonal covariance 1e-4 and the
// register reset values. If the receiver stalls, the result is held in the
// output register and no new item is taken until it is transferred.
module kalman_speed_distance_2state (
    input  logic        clk,
    input  logic        rst_n,
    ksd_if.sink         in_ch,
    ksd_if.source       out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] ADDR_TICK = 4'd0;
    localparam logic [3:0] ADDR_SVAR = 4'd4;
    localparam logic [3:0] ADDR_UVAR = 4'd8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [23:0] tick_reg;
    logic [31:0] svar_reg;
    logic [31:0] uvar_reg;

    logic signed [63:0] pd_reg, ps_reg, p00_reg, p01_reg, p10_reg, p11_reg, integ_reg;
    logic signed [63:0] err_reg, u_reg, k0_reg, k1_reg, dhat_reg, shat_reg;
    logic signed [63:0] q00_reg, q01_reg, q10_reg, q11_reg, ap00_reg, ap01_reg;
    logic signed [63:0] t_reg, b01_reg, dt2_reg, tmp_reg, den_reg;

    logic [1:0] state_reg;
    logic [4:0] pc_reg;
    logic       ovalid_reg;
    logic [95:0] odata_reg;

    ksd_pkg::alu_req_t req;
    ksd_pkg::alu_rsp_t rsp;

    logic signed [63:0] dt;
    logic signed [63:0] omk1;
    logic signed [63:0] meas;
    logic signed [63:0] den;
    logic signed [31:0] sl, sr, ua;
    logic wr;

    ksd_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign dt = 64'(tick_reg);
    assign omk1 = (64'sd1 <<< 32) - k1_reg;
    assign sl = in_ch.data[95:64];
    assign sr = in_ch.data[127:96];
    assign ua = in_ch.data[159:128];
    assign meas = (64'(sl) + 64'(sr)) / 64'sd2;
    assign den = $signed({16'd0, svar_reg, 16'd0}) + p11_reg;

    // Operation sequence; each step picks operands from the working registers.
    always_comb
    begin
        req.start = (state_reg == ST_ISSUE);
        req.op = ksd_pkg::OP_MUL;
        req.a = '0;
        req.b = '0;
        req.sh = 6'd32;
        case (pc_reg)
            5'd0:  begin req.op = ksd_pkg::OP_DIV; req.a = p01_reg; req.b = den_reg; end
            5'd1:  begin req.op = ksd_pkg::OP_DIV; req.a = p11_reg; req.b = den_reg; end
            5'd2:  begin req.a = k0_reg; req.b = err_reg; end
            5'd3:  begin req.a = k1_reg; req.b = err_reg; end
            5'd4:  begin req.a = k0_reg; req.b = p10_reg; end
            5'd5:  begin req.a = k0_reg; req.b = p11_reg; end
            5'd6:  begin req.a = omk1; req.b = p10_reg; end
            5'd7:  begin req.a = omk1; req.b = p11_reg; end
            5'd8:  begin req.a = shat_reg; req.b = dt; req.sh = 6'd24; end
            5'd9:  begin req.a = u_reg; req.b = dt2_reg; req.sh = 6'd49; end
            5'd10: begin req.a = u_reg; req.b = dt; req.sh = 6'd24; end
            5'd11: begin req.a = q10_reg; req.b = dt; req.sh = 6'd24; end
            5'd12: begin req.a = q11_reg; req.b = dt; req.sh = 6'd24; end
            5'd13: begin req.a = 64'(uvar_reg); req.b = dt2_reg; end
            5'd14: begin req.a = t_reg; req.b = dt; req.sh = 6'd25; end
            5'd15: begin req.a = t_reg; req.b = dt2_reg; req.sh = 6'd50; end
            5'd16: begin req.a = ap01_reg; req.b = dt; req.sh = 6'd24; end
            5'd17: begin req.a = q11_reg; req.b = dt; req.sh = 6'd24; end
            default: ;
        endcase
    end

    // Sequencer and datapath state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            ovalid_reg <= 1'b0;
            pd_reg <= '0;
            ps_reg <= '0;
            integ_reg <= '0;
            p00_reg <= 64'(ksd_pkg::COV_INIT);
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= 64'(ksd_pkg::COV_INIT);
            tick_reg <= 24'd16777;
            svar_reg <= 32'd65536;
            uvar_reg <= 32'd65536;
        end
        else
        begin
            if (wr)
            begin
                case (paddr)
                    ADDR_TICK: tick_reg <= pwdata[23:0];
                    ADDR_SVAR: svar_reg <= pwdata;
                    ADDR_UVAR: uvar_reg <= pwdata;
                    default: ;
                endcase
            end
            if (out_ch.ready && ovalid_reg)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid && !ovalid_reg)
                    begin
                        err_reg <= meas - ps_reg;
                        u_reg <= 64'(ua);
                        dt2_reg <= dt * dt;
                        den_reg <= den;
                        k0_reg <= '0;
                        k1_reg <= '0;
                        if (den > 64'sd0)
                            pc_reg <= 5'd0;
                        else
                            pc_reg <= 5'd2;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (rsp.done)
                    begin
                        case (pc_reg)
                            5'd0:  k0_reg <= rsp.res;
                            5'd1:  k1_reg <= rsp.res;
                            5'd2:  dhat_reg <= ksd_pkg::sat32(pd_reg + rsp.res);
                            5'd3:  shat_reg <= ksd_pkg::sat32(ps_reg + rsp.res);
                            5'd4:  q00_reg <= ksd_pkg::sat48(p00_reg - rsp.res);
                            5'd5:  q01_reg <= ksd_pkg::sat48(p01_reg - rsp.res);
                            5'd6:  q10_reg <= ksd_pkg::sat48(rsp.res);
                            5'd7:  q11_reg <= ksd_pkg::sat48(rsp.res);
                            5'd8:
                            begin
                                tmp_reg <= dhat_reg + rsp.res;
                                integ_reg <= ksd_pkg::sat32(integ_reg + rsp.res);
                            end
                            5'd9:  pd_reg <= ksd_pkg::sat32(tmp_reg + rsp.res);
                            5'd10: ps_reg <= ksd_pkg::sat32(shat_reg + rsp.res);
                            5'd11: ap00_reg <= ksd_pkg::sat48(q00_reg + rsp.res);
                            5'd12: ap01_reg <= ksd_pkg::sat48(q01_reg + rsp.res);
                            5'd13: t_reg <= rsp.res;
                            5'd14: b01_reg <= rsp.res;
                            5'd15: tmp_reg <= rsp.res;
                            5'd16:
                            begin
                                p00_reg <= ksd_pkg::sat48(ap00_reg + rsp.res + tmp_reg);
                                p01_reg <= ksd_pkg::sat48(ap01_reg + b01_reg);
                            end
                            5'd17:
                            begin
                                p10_reg <= ksd_pkg::sat48(q10_reg + rsp.res + b01_reg);
                                p11_reg <= ksd_pkg::sat48(q11_reg + t_reg);
                            end
                            default: ;
                        endcase
                        if (pc_reg == 5'd17)
                            state_reg <= ST_OUT;
                        else
                        begin
                            pc_reg <= pc_reg + 5'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    odata_reg <= {integ_reg[31:0], dhat_reg[31:0], shat_reg[31:0]};
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign in_ch.ready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = odata_reg;

    always_comb
    begin
        case (paddr)
            ADDR_TICK: prdata = {8'd0, tick_reg};
            ADDR_SVAR: prdata = svar_reg;
            ADDR_UVAR: prdata = uvar_reg;
            default:   prdata = '0;
        endcase
    end

    // While a result waits for transfer, the sequencer stays idle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> state_reg == ST_IDLE)
        else $error("new item started while result pending");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> state_reg == ST_ISSUE)
        else $error("accepted item did not start the sequence");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(odata_reg))
        else $error("result changed while stalled");

endmodule
